// ===== src/assert_macros.svh =====
// assertion macros for the codebook subtraction rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every rising edge outside reset
`define CBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen outside reset
`define CBS_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CBS_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBS_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/cbs_pkg.sv =====
// shared constants and codeword layout for the codebook subtraction unit
package cbs_pkg;

    localparam int PIXEL_COUNT_DEF   = 16384;
    localparam int MAX_CODEWORDS_DEF = 8;

    localparam int MEAN_W   = 16;
    localparam int BRIGHT_W = 10;
    localparam int HITS_W   = 16;
    localparam int TIME_W   = 16;
    localparam int COLOR_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS      = 2'd3;

    // configuration reset values
    localparam logic       RUN_MODE_RST = 1'b0;
    localparam logic [7:0] ALPHA_RST    = 8'd128;
    localparam logic [9:0] BETA_RST     = 10'd307;
    localparam logic [12:0] EPS_RST     = 13'd160;

    // mode and item kind codes
    localparam logic MODE_PLAY = 1'b1;
    localparam logic FUNC_WRAP = 1'b1;

    localparam logic [7:0] MASK_HIT  = 8'd255;
    localparam logic [7:0] MASK_MISS = 8'd0;

    // one codeword as held in the word memory
    typedef struct packed {
        logic [MEAN_W-1:0]   mean_r;
        logic [MEAN_W-1:0]   mean_g;
        logic [MEAN_W-1:0]   mean_b;
        logic [BRIGHT_W-1:0] lo_i;
        logic [BRIGHT_W-1:0] hi_i;
        logic [HITS_W-1:0]   hits;
        logic [TIME_W-1:0]   gap_l;
        logic [TIME_W-1:0]   first_p;
        logic [TIME_W-1:0]   last_q;
    } cword_t;

endpackage

// ===== src/codebook_background_subtraction_unit.sv =====
// top level: sequencer, codeword memories and result path of the codebook unit
//
// One transaction at a time: a start pulse taken while busy is low begins an item,
// and its result shows on the output ports for one cycle with done high; the
// receiver cannot stall, so the result must be taken in that cycle. The
// codeword store is a single memory with one read and one write port; the
// codeword tests run through a four stage pipeline fed by one read per cycle.
// A sample's scan stops at its first matching slot, or when every word of its
// book has been tested without a match, and an empty book skips the scan; a
// training update of a matched word also waits on the 16 step mean divider.
// A wrap-up item does one read and one write per codeword, and a pixel index
// beyond the book range goes straight to the result. After reset, a clearing
// pass over all PIXEL_COUNT entries (16384 by default) zeroes the per-pixel
// word counts with busy held high; configuration writes are taken throughout.
`include "assert_macros.svh"

module codebook_background_subtraction_unit #(
    parameter int PIXEL_COUNT   = cbs_pkg::PIXEL_COUNT_DEF,
    parameter int MAX_CODEWORDS = cbs_pkg::MAX_CODEWORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          func,
    input  logic [13:0]                   pixel_index,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [15:0]                   time_stamp,
    input  logic                          cfg_write,
    input  logic [cbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          done,
    output logic [7:0]                    mask,
    output logic                          matched,
    output logic [2:0]                    match_slot,
    output logic                          book_full,
    output logic [3:0]                    words_in_pixel
);

    localparam int PA_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int WORDS = PIXEL_COUNT * MAX_CODEWORDS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CW    = $clog2(MAX_CODEWORDS + 1);
    localparam int SW    = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1;

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_COUNT   = 4'd2;
    localparam logic [3:0] ST_SCAN    = 4'd3;
    localparam logic [3:0] ST_DECIDE  = 4'd4;
    localparam logic [3:0] ST_MUL     = 4'd5;
    localparam logic [3:0] ST_DIV     = 4'd6;
    localparam logic [3:0] ST_WRAP_RD = 4'd7;
    localparam logic [3:0] ST_WRAP_WR = 4'd8;
    localparam logic [3:0] ST_RESULT  = 4'd9;

    // configuration registers
    logic        run_mode_reg;
    logic [7:0]  alpha_reg;
    logic [9:0]  beta_reg;
    logic [12:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg <= cbs_pkg::RUN_MODE_RST;
            alpha_reg    <= cbs_pkg::ALPHA_RST;
            beta_reg     <= cbs_pkg::BETA_RST;
            eps_reg      <= cbs_pkg::EPS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                cbs_pkg::CFG_RUN_MODE: run_mode_reg <= cfg_data[0];
                cbs_pkg::CFG_ALPHA:    alpha_reg    <= cfg_data[7:0];
                cbs_pkg::CFG_BETA:     beta_reg     <= cfg_data[9:0];
                cbs_pkg::CFG_EPS:      eps_reg      <= cfg_data[12:0];
                default:               run_mode_reg <= run_mode_reg;
            endcase
        end
    end

    // control registers
    logic [3:0]      state_reg, state_next;
    logic [PA_W-1:0] clr_addr_reg, clr_addr_next;
    logic            rd_valid_reg, rd_valid_next;
    logic [17:0]     total_reg, total_next;

    // item registers
    logic                func_reg, func_next;
    logic [PA_W-1:0]     pix_reg, pix_next;
    logic [WA_W-1:0]     base_reg, base_next;
    logic [7:0]          x_reg [3];
    logic [7:0]          x_next [3];
    logic [9:0]          bright_reg, bright_next;
    logic [15:0]         t_reg, t_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic [SW-1:0]       rd_slot_reg, rd_slot_next;
    logic                hit_reg, hit_next;
    logic [SW-1:0]       hit_slot_reg, hit_slot_next;
    cbs_pkg::cword_t     hit_word_reg, hit_word_next;
    logic                full_reg, full_next;
    logic [31:0]         prod_reg [3];
    logic [31:0]         prod_next [3];

    // memories
    cbs_pkg::cword_t     word_mem [WORDS];
    cbs_pkg::cword_t     wm_rd_reg;
    logic                wm_we;
    logic [WA_W-1:0]     wm_waddr;
    cbs_pkg::cword_t     wm_wdata;
    logic [WA_W-1:0]     wm_raddr;

    logic [CW-1:0]       pc_mem [PIXEL_COUNT];
    logic [CW-1:0]       pc_rd_reg;
    logic                pc_we;
    logic [PA_W-1:0]     pc_waddr;
    logic [CW-1:0]       pc_wdata;
    logic [PA_W-1:0]     pc_raddr;

    // pixel address and codebook base from the input index
    logic [31:0]         pix32;
    logic [31:0]         base_full;
    logic                in_range;

    always_comb
    begin
        pix32     = 32'(pixel_index);
        base_full = pix32 * 32'(MAX_CODEWORDS);
        in_range  = pix32 < 32'(PIXEL_COUNT);
        pc_raddr  = pix32[PA_W-1:0];
        wm_raddr  = base_reg + WA_W'(issue_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wm_we)
        begin
            word_mem[wm_waddr] <= wm_wdata;
        end
        wm_rd_reg <= word_mem[wm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pc_we)
        begin
            pc_mem[pc_waddr] <= pc_wdata;
        end
        pc_rd_reg <= pc_mem[pc_raddr];
    end

    // codeword test pipeline
    logic                mt_valid;
    logic [SW-1:0]       mt_slot;
    logic                mt_fit;
    cbs_pkg::cword_t     mt_word;
    logic                flush;

    cbs_match #(
        .SLOT_W (SW)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (flush),
        .in_valid  (rd_valid_reg),
        .in_slot   (rd_slot_reg),
        .word      (wm_rd_reg),
        .red       (x_reg[0]),
        .green     (x_reg[1]),
        .blue      (x_reg[2]),
        .bright    (bright_reg),
        .alpha     (alpha_reg),
        .beta      (beta_reg),
        .eps       (eps_reg),
        .out_valid (mt_valid),
        .out_slot  (mt_slot),
        .out_fit   (mt_fit),
        .out_word  (mt_word)
    );

    // mean update dividers, one lane per channel
    logic        div_start;
    logic [31:0] div_dvd [3];
    logic [16:0] fn;
    logic [2:0]  div_done;
    logic [15:0] div_q [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        cbs_divider u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (div_dvd[c]),
            .divisor  (fn),
            .done     (div_done[c]),
            .quotient (div_q[c])
        );
    end

    // update arithmetic for the matched codeword
    logic [15:0]     hit_mean [3];
    cbs_pkg::cword_t upd_word;
    cbs_pkg::cword_t new_word;
    cbs_pkg::cword_t wrap_word;
    logic [15:0]     gap;
    logic [15:0]     run_len;

    always_comb
    begin
        hit_mean[0] = hit_word_reg.mean_r;
        hit_mean[1] = hit_word_reg.mean_g;
        hit_mean[2] = hit_word_reg.mean_b;
        fn          = 17'(hit_word_reg.hits) + 17'd1;
        for (int c = 0; c < 3; c++)
        begin
            div_dvd[c] = prod_reg[c] + {16'd0, x_reg[c], 8'd0} + 32'(fn >> 1);
        end

        gap              = t_reg - hit_word_reg.last_q;
        upd_word         = hit_word_reg;
        upd_word.mean_r  = div_q[0];
        upd_word.mean_g  = div_q[1];
        upd_word.mean_b  = div_q[2];
        upd_word.lo_i    = (bright_reg < hit_word_reg.lo_i) ? bright_reg : hit_word_reg.lo_i;
        upd_word.hi_i    = (bright_reg > hit_word_reg.hi_i) ? bright_reg : hit_word_reg.hi_i;
        upd_word.hits    = (hit_word_reg.hits == 16'hFFFF) ? hit_word_reg.hits
                                                            : hit_word_reg.hits + 16'd1;
        upd_word.gap_l   = (gap > hit_word_reg.gap_l) ? gap : hit_word_reg.gap_l;
        upd_word.last_q  = t_reg;

        new_word.mean_r  = {x_reg[0], 8'd0};
        new_word.mean_g  = {x_reg[1], 8'd0};
        new_word.mean_b  = {x_reg[2], 8'd0};
        new_word.lo_i    = bright_reg;
        new_word.hi_i    = bright_reg;
        new_word.hits    = 16'd1;
        new_word.gap_l   = t_reg - 16'd1;
        new_word.first_p = t_reg;
        new_word.last_q  = t_reg;

        run_len          = t_reg - wm_rd_reg.last_q + wm_rd_reg.first_p - 16'd1;
        wrap_word        = wm_rd_reg;
        wrap_word.gap_l  = (run_len > wm_rd_reg.gap_l) ? run_len : wm_rd_reg.gap_l;
    end

    // sequencer
    logic leave;
    logic issue;

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        total_next    = total_reg;
        func_next     = func_reg;
        pix_next      = pix_reg;
        base_next     = base_reg;
        x_next        = x_reg;
        bright_next   = bright_reg;
        t_next        = t_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        rd_slot_next  = issue_reg[SW-1:0];
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        hit_word_next = hit_word_reg;
        full_next     = full_reg;
        prod_next     = prod_reg;

        wm_we     = 1'b0;
        wm_waddr  = base_reg + WA_W'(issue_reg);
        wm_wdata  = wrap_word;
        pc_we     = 1'b0;
        pc_waddr  = clr_addr_reg;
        pc_wdata  = '0;
        div_start = 1'b0;

        leave = (state_reg == ST_SCAN) && mt_valid
                && (mt_fit || ((CW'(mt_slot) + CW'(1)) == count_reg));
        issue = (state_reg == ST_SCAN) && (issue_reg < count_reg) && !leave;
        flush = leave;
        rd_valid_next = issue;

        case (state_reg)
            ST_CLEAR:
            begin
                pc_we         = 1'b1;
                clr_addr_next = clr_addr_reg + PA_W'(1);
                if (32'(clr_addr_reg) == 32'(PIXEL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next   = func;
                    pix_next    = pix32[PA_W-1:0];
                    base_next   = base_full[WA_W-1:0];
                    x_next[0]   = red;
                    x_next[1]   = green;
                    x_next[2]   = blue;
                    bright_next = 10'(red) + 10'(green) + 10'(blue);
                    t_next      = time_stamp;
                    count_next  = '0;
                    hit_next    = 1'b0;
                    full_next   = 1'b0;
                    state_next  = in_range ? ST_COUNT : ST_RESULT;
                end
            end
            ST_COUNT:
            begin
                count_next = pc_rd_reg;
                issue_next = '0;
                if (pc_rd_reg == '0)
                begin
                    state_next = (func_reg == cbs_pkg::FUNC_WRAP) ? ST_RESULT : ST_DECIDE;
                end
                else
                begin
                    state_next = (func_reg == cbs_pkg::FUNC_WRAP) ? ST_WRAP_RD : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    issue_next = issue_reg + CW'(1);
                end
                if (leave)
                begin
                    hit_next      = mt_fit;
                    hit_slot_next = mt_slot;
                    hit_word_next = mt_word;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (run_mode_reg == cbs_pkg::MODE_PLAY)
                begin
                    state_next = ST_RESULT;
                end
                else if (!hit_reg)
                begin
                    if (32'(count_reg) < 32'(MAX_CODEWORDS))
                    begin
                        wm_we      = 1'b1;
                        wm_waddr   = base_reg + WA_W'(count_reg);
                        wm_wdata   = new_word;
                        pc_we      = 1'b1;
                        pc_waddr   = pix_reg;
                        pc_wdata   = count_reg + CW'(1);
                        count_next = count_reg + CW'(1);
                        total_next = total_reg + 18'd1;
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                    state_next = ST_RESULT;
                end
                else
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        prod_next[c] = 32'(hit_word_reg.hits) * 32'(hit_mean[c]);
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done[0])
                begin
                    wm_we      = 1'b1;
                    wm_waddr   = base_reg + WA_W'(hit_slot_reg);
                    wm_wdata   = upd_word;
                    state_next = ST_RESULT;
                end
            end
            ST_WRAP_RD:
            begin
                state_next = ST_WRAP_WR;
            end
            ST_WRAP_WR:
            begin
                wm_we      = 1'b1;
                issue_next = issue_reg + CW'(1);
                state_next = ((issue_reg + CW'(1)) == count_reg) ? ST_RESULT : ST_WRAP_RD;
            end
            ST_RESULT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_valid_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_valid_reg <= rd_valid_next;
            total_reg    <= total_next;
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        pix_reg      <= pix_next;
        base_reg     <= base_next;
        x_reg        <= x_next;
        bright_reg   <= bright_next;
        t_reg        <= t_next;
        count_reg    <= count_next;
        issue_reg    <= issue_next;
        rd_slot_reg  <= rd_slot_next;
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        hit_word_reg <= hit_word_next;
        full_reg     <= full_next;
        prod_reg     <= prod_next;
    end

    // result transaction
    logic [31:0] count32;
    logic [31:0] slot32;

    always_comb
    begin
        count32        = 32'(count_reg);
        slot32         = 32'(hit_slot_reg);
        busy           = state_reg != ST_IDLE;
        done           = state_reg == ST_RESULT;
        mask           = (hit_reg && run_mode_reg == cbs_pkg::MODE_PLAY)
                         ? cbs_pkg::MASK_HIT : cbs_pkg::MASK_MISS;
        matched        = hit_reg;
        match_slot     = hit_reg ? slot32[2:0] : 3'd0;
        book_full      = full_reg;
        words_in_pixel = count32[3:0];
    end

    `CBS_ASSERT(a_accept_busy, clk, rst_n, (start && !busy) |=> busy, "accepted item did not raise busy")
    `CBS_ASSERT(a_done_after_busy, clk, rst_n, done |-> $past(start || busy), "result without a pending item")
    `CBS_ASSERT(a_count_bound, clk, rst_n, pc_we |-> (32'(pc_wdata) <= 32'(MAX_CODEWORDS)), "word count above book size")
    `CBS_NEVER(a_no_write_in_scan, clk, rst_n, wm_we && (state_reg == ST_SCAN), "word store written during scan")
    `CBS_NEVER(a_div_done_state, clk, rst_n, (div_done != 3'd0) && (state_reg != ST_DIV), "divider finished outside wait")

endmodule

// ===== src/cbs_match.sv =====
// pipelined colour distortion and brightness test for one codeword per cycle
module cbs_match #(
    parameter int SLOT_W = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  flush,
    input  logic                  in_valid,
    input  logic [SLOT_W-1:0]     in_slot,
    input  cbs_pkg::cword_t       word,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    input  logic [9:0]            bright,
    input  logic [7:0]            alpha,
    input  logic [9:0]            beta,
    input  logic [12:0]           eps,
    output logic                  out_valid,
    output logic [SLOT_W-1:0]     out_slot,
    output logic                  out_fit,
    output cbs_pkg::cword_t       out_word
);

    // sample and threshold squares, stable while the sample and eps hold
    logic [17:0] xx_reg;
    logic [25:0] eps_sq_reg;

    always_ff @(posedge clk)
    begin
        xx_reg     <= 18'(red) * 18'(red) + 18'(green) * 18'(green) + 18'(blue) * 18'(blue);
        eps_sq_reg <= 26'(eps) * 26'(eps);
    end

    // stage a: per channel products and brightness window
    logic [15:0] mean_v [3];
    logic [7:0]  x_v    [3];
    logic        bok;
    logic [17:0] bright_sh;
    logic [17:0] alpha_hi;
    logic [19:0] beta_hi;
    logic [17:0] bright_alpha;
    logic [17:0] lo_sh;

    always_comb
    begin
        mean_v[0]    = word.mean_r;
        mean_v[1]    = word.mean_g;
        mean_v[2]    = word.mean_b;
        x_v[0]       = red;
        x_v[1]       = green;
        x_v[2]       = blue;
        bright_sh    = {bright, 8'd0};
        alpha_hi     = 18'(alpha) * 18'(word.hi_i);
        beta_hi      = 20'(beta) * 20'(word.hi_i);
        bright_alpha = 18'(bright) * 18'(alpha);
        lo_sh        = {word.lo_i, 8'd0};
        bok = !(alpha_hi > bright_sh) && !(20'(bright_sh) > beta_hi)
              && !(bright_alpha > lo_sh);
    end

    logic                  a_valid_reg;
    logic [SLOT_W-1:0]     a_slot_reg;
    cbs_pkg::cword_t       a_word_reg;
    logic [31:0]           a_sq_reg [3];
    logic [23:0]           a_xm_reg [3];
    logic                  a_bok_reg;

    logic                  b_valid_reg;
    logic [SLOT_W-1:0]     b_slot_reg;
    cbs_pkg::cword_t       b_word_reg;
    logic [33:0]           b_vv_reg;
    logic [25:0]           b_xv_reg;
    logic                  b_bok_reg;

    logic                  c_valid_reg;
    logic [SLOT_W-1:0]     c_slot_reg;
    cbs_pkg::cword_t       c_word_reg;
    logic [51:0]           c_p1_reg;
    logic [51:0]           c_p2_reg;
    logic [59:0]           c_p3_reg;
    logic                  c_ok_reg;

    logic                  d_valid_reg;
    logic [SLOT_W-1:0]     d_slot_reg;
    cbs_pkg::cword_t       d_word_reg;
    logic                  d_fit_reg;

    // valid bits of the four stages, cleared on flush
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid && !flush;
            b_valid_reg <= a_valid_reg && !flush;
            c_valid_reg <= b_valid_reg && !flush;
            d_valid_reg <= c_valid_reg && !flush;
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        a_slot_reg <= in_slot;
        a_word_reg <= word;
        a_bok_reg  <= bok;
        for (int c = 0; c < 3; c++)
        begin
            a_sq_reg[c] <= 32'(mean_v[c]) * 32'(mean_v[c]);
            a_xm_reg[c] <= 24'(x_v[c]) * 24'(mean_v[c]);
        end

        b_slot_reg <= a_slot_reg;
        b_word_reg <= a_word_reg;
        b_bok_reg  <= a_bok_reg;
        b_vv_reg   <= 34'(a_sq_reg[0]) + 34'(a_sq_reg[1]) + 34'(a_sq_reg[2]);
        b_xv_reg   <= 26'(a_xm_reg[0]) + 26'(a_xm_reg[1]) + 26'(a_xm_reg[2]);

        c_slot_reg <= b_slot_reg;
        c_word_reg <= b_word_reg;
        c_ok_reg   <= b_bok_reg && (b_vv_reg != 34'd0);
        c_p1_reg   <= 52'(xx_reg) * 52'(b_vv_reg);
        c_p2_reg   <= 52'(b_xv_reg) * 52'(b_xv_reg);
        c_p3_reg   <= 60'(eps_sq_reg) * 60'(b_vv_reg);

        d_slot_reg <= c_slot_reg;
        d_word_reg <= c_word_reg;
        d_fit_reg  <= c_ok_reg && ({c_p1_reg - c_p2_reg, 8'd0} <= c_p3_reg);
    end

    assign out_valid = d_valid_reg;
    assign out_slot  = d_slot_reg;
    assign out_fit   = d_fit_reg;
    assign out_word  = d_word_reg;

endmodule

// ===== src/cbs_divider.sv =====
// restoring divider, one quotient bit per cycle, for the running mean update
module cbs_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    localparam logic [3:0] LAST_STEP = 4'd15;

    logic        run_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] rem_reg;
    logic [15:0] shf_reg;
    logic [16:0] dsr_reg;

    logic [16:0] trial;
    logic        ge;
    logic [16:0] diff;

    // quotient is known to fit 16 bits, so the high half starts below the divisor
    always_comb
    begin
        trial = {rem_reg, shf_reg[15]};
        ge    = trial >= dsr_reg;
        diff  = trial - dsr_reg;
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 4'd0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[31:16];
            shf_reg <= dividend[15:0];
            dsr_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[15:0] : trial[15:0];
            shf_reg <= {shf_reg[14:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

endmodule
